### rtl/min_priority_queue_id_macros.svh
// assertion macros shared by the queue checker
`ifndef MIN_PRIORITY_QUEUE_ID_MACROS_SVH
`define MIN_PRIORITY_QUEUE_ID_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("queue check failed: same-cycle rule");

// next-cycle implication, quiet while reset is held
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("queue check failed: next-cycle rule");

`endif

### rtl/mpq_pkg.sv
// shared types and constants of the min priority queue
package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int WT_W     = 32;
    localparam int ST_W     = 2;
    localparam int OCC_W    = 5;

    localparam logic FN_PUSH = 1'b0;
    localparam logic FN_POP  = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic signed [WT_W-1:0] weight;
    } t_entry;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry item;
    } t_ctl;

endpackage

### rtl/min_priority_queue_id.sv
// top level of the bounded min priority queue of (id, weight) entries
//
//  channel  | signals                                      | dir | handshake
//  ---------+----------------------------------------------+-----+---------------------
//  command  | i_func, i_item_id, i_item_weight             | in  | start high, busy low
//  result   | o_out_id, o_out_weight, o_status, o_occupancy| out | o_valid, one cycle
//
//  one operation per clock: a command beat updates the whole chain at the edge that takes it
//  the result beat follows on the next cycle, held for that single cycle only
//  throughput is set by the chain of cells, which compare and shift in parallel
//  busy stays low, so back-to-back commands are taken every cycle
//  synchronous active-low reset empties the queue; slot contents stay undefined
//  the receiver cannot stall, so no result is ever held back
module min_priority_queue_id (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [mpq_pkg::ID_W-1:0]         i_item_id,
    input  logic signed [mpq_pkg::WT_W-1:0]  i_item_weight,
    output logic                             o_valid,
    output logic [mpq_pkg::ID_W-1:0]         o_out_id,
    output logic signed [mpq_pkg::WT_W-1:0]  o_out_weight,
    output logic [mpq_pkg::ST_W-1:0]         o_status,
    output logic [mpq_pkg::OCC_W-1:0]        o_occupancy
);
    import mpq_pkg::*;

    // occupancy counter; the slots themselves carry no valid flags
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // registered result beat
    logic                   r_valid;
    logic [ID_W-1:0]        r_id;
    logic signed [WT_W-1:0] r_weight;
    logic [ST_W-1:0]        r_status;
    logic [CNT_W-1:0]       r_occ;

    logic                   n_valid;
    logic [ID_W-1:0]        n_id;
    logic signed [WT_W-1:0] n_weight;
    logic [ST_W-1:0]        n_status;

    logic   w_accept;
    logic   w_full;
    logic   w_empty;
    t_ctl   w_ctl;

    t_entry               w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_ge;
    logic [CAPACITY-1:0]  w_occ;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // broadcast to the chain; a push on a full queue is dropped here
    assign w_ctl.push        = w_accept && (i_func == FN_PUSH) && !w_full;
    assign w_ctl.pop         = w_accept && (i_func == FN_POP) && !w_empty;
    assign w_ctl.item.id     = i_item_id;
    assign w_ctl.item.weight = i_item_weight;

    // chain of cells: slot 0 holds the next entry to leave
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_ge;

        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left    = w_ctl.item;
            assign w_left_ge = 1'b0;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_ge = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        mpq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_occ     (w_occ[g]),
            .i_left_ge (w_left_ge),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_ge      (w_ge[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_valid  = w_accept;
        n_id     = '0;
        n_weight = '0;
        n_status = ST_DONE;
        if (w_accept) begin
            case (i_func)
                FN_PUSH: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                FN_POP: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_id     = w_entry[0].id;
                        n_weight = w_entry[0].weight;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_id     <= n_id;
        r_weight <= n_weight;
        r_status <= n_status;
        r_occ    <= n_count;
    end

    assign o_valid      = r_valid;
    assign o_out_id     = r_id;
    assign o_out_weight = r_weight;
    assign o_status     = r_status;
    assign o_occupancy  = OCC_W'(r_occ);

endmodule

### rtl/mpq_cell.sv
// one slot of the sorted chain: compares the broadcast key and shifts
module mpq_cell (
    input  logic           i_clk,
    input  mpq_pkg::t_ctl  i_ctl,
    input  logic           i_occ,
    input  logic           i_left_ge,
    input  mpq_pkg::t_entry i_left,
    input  mpq_pkg::t_entry i_right,
    output mpq_pkg::t_entry o_entry,
    output logic           o_ge
);
    import mpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // empty slots count as heavier; equal weights let the new entry go first
    assign o_ge    = !i_occ || (r_entry.weight >= i_ctl.item.weight);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push && o_ge) begin
            n_entry = i_left_ge ? i_left : i_ctl.item;
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/mpq_checker.sv
// port-level checks of the min priority queue, bound to the top level
`include "min_priority_queue_id_macros.svh"

module mpq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic [mpq_pkg::ID_W-1:0]         o_out_id,
    input logic signed [mpq_pkg::WT_W-1:0]  o_out_weight,
    input logic [mpq_pkg::ST_W-1:0]         o_status,
    input logic [mpq_pkg::OCC_W-1:0]        o_occupancy
);
    import mpq_pkg::*;

    // every command beat gives exactly one result beat on the next cycle
    `MPQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_valid)
    `MPQ_ASSERT_NEXT(a_no_spare_result, i_clk, i_rst_n, !(start && !busy), !o_valid)

    // a pop on an empty queue returns nothing and leaves it empty
    `MPQ_ASSERT_NOW(a_empty_pop, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY),
        (o_occupancy == '0) && (o_out_id == '0) && (o_out_weight == '0))

    // a dropped push leaves the queue full and returns nothing
    `MPQ_ASSERT_NOW(a_full_push, i_clk, i_rst_n, o_valid && (o_status == ST_FULL),
        (o_occupancy == OCC_W'(CAPACITY)) && (o_out_id == '0) && (o_out_weight == '0))

endmodule

bind min_priority_queue_id mpq_checker u_mpq_checker (.*);
